@@ rtl/matrix3x3_inverse_top_assert.svh @@
// Assertion macros for the 3x3 matrix inverse block.
// Used by matrix3x3_inverse_top; no other dependencies.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH

// same-cycle implication
`define MI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication
`define MI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

@@ rtl/mi_pkg.sv @@
// Shared widths, types and the adjugate operand table for the matrix inverse.
// No dependencies.
`default_nettype none
package mi_pkg;
   localparam int ENTRY_W = 32;
   localparam int PROD_W  = 64;
   localparam int ADJ_W   = 65;
   localparam int PART_W  = 65;
   localparam int DET_W   = 99;
   localparam int QUOT_W  = 32;
   localparam int N_ENTRY = 9;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ADJ_W-1:0]   adj_type;
   typedef logic signed [PART_W-1:0]  part_type;
   typedef logic signed [DET_W-1:0]   det_type;
   typedef logic [DET_W-1:0]          dmag_type;
   typedef logic [ADJ_W-1:0]          amag_type;
   typedef logic [QUOT_W-1:0]         quot_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] det_q;
      logic               det_ovf;
      logic               singular;
      logic [N_ENTRY-1:0] sneg;
   } side_type;

   localparam logic [ENTRY_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ENTRY_W-1:0] SAT_NEG = 32'h8000_0000;

   // adj[i] = m[op0]*m[op1] - m[op2]*m[op3]
   localparam logic [3:0] ADJ_OP [N_ENTRY][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };
endpackage
`default_nettype wire

@@ rtl/mi_adj.sv @@
// Adjugate stages: cofactor products, then differences.
// Depends on mi_pkg.
`default_nettype none
module mi_adj (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              v_i,
   input  mi_pkg::entry_type m_i   [mi_pkg::N_ENTRY],
   output logic              v_o,
   output mi_pkg::adj_type   adj_o [mi_pkg::N_ENTRY],
   output mi_pkg::entry_type abc_o [3]
);
   import mi_pkg::*;

   logic      v1_ff, v2_ff;
   prod_type  p_ff   [2*N_ENTRY];
   prod_type  p_in   [2*N_ENTRY];
   entry_type abc1_ff [3];
   entry_type abc2_ff [3];
   adj_type   adj_ff [N_ENTRY];
   adj_type   adj_in [N_ENTRY];

   always_comb begin
      for (int i = 0; i < N_ENTRY; i++) begin
         p_in[2*i]   = prod_type'(m_i[ADJ_OP[i][0]]) * prod_type'(m_i[ADJ_OP[i][1]]);
         p_in[2*i+1] = prod_type'(m_i[ADJ_OP[i][2]]) * prod_type'(m_i[ADJ_OP[i][3]]);
         adj_in[i]   = adj_type'(p_ff[2*i]) - adj_type'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v_i;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         adj_ff  <= adj_in;
         abc1_ff <= '{m_i[0], m_i[1], m_i[2]};
         abc2_ff <= abc1_ff;
      end
   end

   assign v_o   = v2_ff;
   assign adj_o = adj_ff;
   assign abc_o = abc2_ff;
endmodule
`default_nettype wire

@@ rtl/mi_det.sv @@
// Determinant stages: partial products, sum, then sign and magnitude split.
// Depends on mi_pkg.
`default_nettype none
module mi_det #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              v_i,
   input  mi_pkg::adj_type   adj_i [mi_pkg::N_ENTRY],
   input  mi_pkg::entry_type abc_i [3],
   output logic              v_o,
   output mi_pkg::amag_type  amag_o [mi_pkg::N_ENTRY],
   output mi_pkg::dmag_type  dmag_o,
   output mi_pkg::side_type  side_o
);
   import mi_pkg::*;

   logic     v3_ff, v4_ff, v5_ff;
   part_type ph_ff [3];
   part_type pl_ff [3];
   part_type ph_in [3];
   part_type pl_in [3];
   adj_type  adj3_ff [N_ENTRY];
   adj_type  adj4_ff [N_ENTRY];
   det_type  det_ff, det_in;
   amag_type amag_ff [N_ENTRY];
   amag_type amag_in [N_ENTRY];
   dmag_type dmag_ff, dmag_in, dq;
   side_type side_ff, side_in;
   logic     dneg;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = part_type'(abc_i[j]) * part_type'($signed(adj_i[3*j][ADJ_W-1:32]));
         pl_in[j] = part_type'(abc_i[j]) * part_type'($signed({1'b0, adj_i[3*j][31:0]}));
      end
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (det_type'(ph_ff[j]) <<< 32) + det_type'(pl_ff[j]);
      end
   end

   always_comb begin
      dneg    = det_ff[DET_W-1];
      dmag_in = dneg ? dmag_type'(-det_ff) : dmag_type'(det_ff);
      dq      = dmag_in >> (2 * FRAC_BITS);
      side_in.singular = (det_ff == '0);
      side_in.det_ovf  = 1'b0;
      if (dneg) begin
         if (dq > dmag_type'(SAT_NEG)) begin
            side_in.det_q   = SAT_NEG;
            side_in.det_ovf = 1'b1;
         end else begin
            side_in.det_q = ENTRY_W'(0) - dq[ENTRY_W-1:0];
         end
      end else begin
         if (dq > dmag_type'(SAT_POS)) begin
            side_in.det_q   = SAT_POS;
            side_in.det_ovf = 1'b1;
         end else begin
            side_in.det_q = dq[ENTRY_W-1:0];
         end
      end
      for (int i = 0; i < N_ENTRY; i++) begin
         side_in.sneg[i] = adj4_ff[i][ADJ_W-1] ^ dneg;
         amag_in[i] = adj4_ff[i][ADJ_W-1] ? amag_type'(-adj4_ff[i]) : amag_type'(adj4_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v_i;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         adj3_ff <= adj_i;
         det_ff  <= det_in;
         adj4_ff <= adj3_ff;
         amag_ff <= amag_in;
         dmag_ff <= dmag_in;
         side_ff <= side_in;
      end
   end

   assign v_o    = v5_ff;
   assign amag_o = amag_ff;
   assign dmag_o = dmag_ff;
   assign side_o = side_ff;
endmodule
`default_nettype wire

@@ rtl/mi_div_step.sv @@
// One restoring division stage, nine lanes sharing one divisor.
// Depends on mi_pkg.
`default_nettype none
module mi_div_step #(
   parameter  int FRAC_BITS = 16,
   parameter  int STEP      = 0,
   localparam int NW = mi_pkg::ADJ_W + 2 * FRAC_BITS,
   localparam int RW = (NW > mi_pkg::DET_W + mi_pkg::QUOT_W) ?
                       NW : mi_pkg::DET_W + mi_pkg::QUOT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       v_i,
   input  logic [RW-1:0]              r_i   [mi_pkg::N_ENTRY],
   input  mi_pkg::quot_type           q_i   [mi_pkg::N_ENTRY],
   input  logic [mi_pkg::N_ENTRY-1:0] ovf_i,
   input  mi_pkg::dmag_type           d_i,
   input  mi_pkg::side_type           side_i,
   output logic                       v_o,
   output logic [RW-1:0]              r_o   [mi_pkg::N_ENTRY],
   output mi_pkg::quot_type           q_o   [mi_pkg::N_ENTRY],
   output logic [mi_pkg::N_ENTRY-1:0] ovf_o,
   output mi_pkg::dmag_type           d_o,
   output mi_pkg::side_type           side_o
);
   import mi_pkg::*;

   logic                v_ff;
   logic [RW-1:0]       dk;
   logic [RW-1:0]       r_ff [N_ENTRY];
   logic [RW-1:0]       r_in [N_ENTRY];
   quot_type            q_ff [N_ENTRY];
   quot_type            q_in [N_ENTRY];
   logic [N_ENTRY-1:0]  ovf_ff;
   dmag_type            d_ff;
   side_type            side_ff;

   assign dk = {{(RW-DET_W){1'b0}}, d_i} << STEP;

   always_comb begin
      for (int i = 0; i < N_ENTRY; i++) begin
         if (r_i[i] >= dk) begin
            r_in[i] = r_i[i] - dk;
            q_in[i] = q_i[i] | (quot_type'(1) << STEP);
         end else begin
            r_in[i] = r_i[i];
            q_in[i] = q_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         q_ff    <= q_in;
         ovf_ff  <= ovf_i;
         d_ff    <= d_i;
         side_ff <= side_i;
      end
   end

   assign v_o    = v_ff;
   assign r_o    = r_ff;
   assign q_o    = q_ff;
   assign ovf_o  = ovf_ff;
   assign d_o    = d_ff;
   assign side_o = side_ff;
endmodule
`default_nettype wire

@@ rtl/matrix3x3_inverse_top.sv @@
// Pipeline stages from request accept to result valid: 2 adjugate, 3 determinant,
// 1 range check, 32 divide, 1 output stage. Throughput: one request per cycle unless the output stalls.
// The whole pipeline advances when the output register is empty or taken, so a
// stalled result holds every stage. Synchronous reset clears all valid bits only.
// Depends on mi_pkg, mi_adj, mi_det, mi_div_step, matrix3x3_inverse_top_assert.svh.
`default_nettype none
`include "matrix3x3_inverse_top_assert.svh"
module matrix3x3_inverse_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mi_pkg::entry_type req_m00,
   input  mi_pkg::entry_type req_m01,
   input  mi_pkg::entry_type req_m02,
   input  mi_pkg::entry_type req_m10,
   input  mi_pkg::entry_type req_m11,
   input  mi_pkg::entry_type req_m12,
   input  mi_pkg::entry_type req_m20,
   input  mi_pkg::entry_type req_m21,
   input  mi_pkg::entry_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mi_pkg::entry_type rsp_inv00,
   output mi_pkg::entry_type rsp_inv01,
   output mi_pkg::entry_type rsp_inv02,
   output mi_pkg::entry_type rsp_inv10,
   output mi_pkg::entry_type rsp_inv11,
   output mi_pkg::entry_type rsp_inv12,
   output mi_pkg::entry_type rsp_inv20,
   output mi_pkg::entry_type rsp_inv21,
   output mi_pkg::entry_type rsp_inv22,
   output mi_pkg::entry_type rsp_determinant,
   output logic              rsp_singular,
   output logic              rsp_overflow
);
   import mi_pkg::*;

   localparam int NW = ADJ_W + 2 * FRAC_BITS;
   localparam int RW = (NW > DET_W + QUOT_W) ? NW : DET_W + QUOT_W;

   logic      en;
   entry_type m_in [N_ENTRY];

   logic      adj_v;
   adj_type   adj   [N_ENTRY];
   entry_type abc   [3];

   logic      det_v;
   amag_type  amag  [N_ENTRY];
   dmag_type  dmag;
   side_type  side;

   logic               pre_v_ff;
   logic [RW-1:0]      pre_r_ff  [N_ENTRY];
   logic [RW-1:0]      pre_r_in  [N_ENTRY];
   logic [N_ENTRY-1:0] pre_ovf_ff, pre_ovf_in;
   dmag_type           pre_d_ff;
   side_type           pre_side_ff;
   quot_type           q_zero    [N_ENTRY];

   logic               s_v    [QUOT_W];
   logic [RW-1:0]      s_r    [QUOT_W][N_ENTRY];
   quot_type           s_q    [QUOT_W][N_ENTRY];
   logic [N_ENTRY-1:0] s_ovf  [QUOT_W];
   dmag_type           s_d    [QUOT_W];
   side_type           s_side [QUOT_W];

   logic      out_v_ff;
   entry_type inv_ff [N_ENTRY];
   entry_type inv_in [N_ENTRY];
   entry_type det_ff, det_in;
   logic      sing_ff, sing_in;
   logic      ovf_ff, ovf_in;

   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;
   assign m_in = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                   req_m20, req_m21, req_m22};

   mi_adj u_adj (
      .clock (clock), .reset (reset), .en (en), .v_i (req_valid),
      .m_i (m_in), .v_o (adj_v), .adj_o (adj), .abc_o (abc)
   );

   mi_det #(.FRAC_BITS (FRAC_BITS)) u_det (
      .clock (clock), .reset (reset), .en (en), .v_i (adj_v),
      .adj_i (adj), .abc_i (abc), .v_o (det_v),
      .amag_o (amag), .dmag_o (dmag), .side_o (side)
   );

   // quotient must fit 32 bits, else the lane saturates
   always_comb begin
      for (int i = 0; i < N_ENTRY; i++) begin
         pre_r_in[i]   = {{(RW-ADJ_W){1'b0}}, amag[i]} << (2 * FRAC_BITS);
         pre_ovf_in[i] = pre_r_in[i] >= ({{(RW-DET_W){1'b0}}, dmag} << QUOT_W);
         q_zero[i]     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
      end else if (en) begin
         pre_v_ff <= det_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_r_ff    <= pre_r_in;
         pre_ovf_ff  <= pre_ovf_in;
         pre_d_ff    <= dmag;
         pre_side_ff <= side;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      if (k == 0) begin : g_first
         mi_div_step #(.FRAC_BITS (FRAC_BITS), .STEP (QUOT_W-1-k)) u_step (
            .clock (clock), .reset (reset), .en (en),
            .v_i (pre_v_ff), .r_i (pre_r_ff), .q_i (q_zero), .ovf_i (pre_ovf_ff),
            .d_i (pre_d_ff), .side_i (pre_side_ff),
            .v_o (s_v[k]), .r_o (s_r[k]), .q_o (s_q[k]), .ovf_o (s_ovf[k]),
            .d_o (s_d[k]), .side_o (s_side[k])
         );
      end else begin : g_next
         mi_div_step #(.FRAC_BITS (FRAC_BITS), .STEP (QUOT_W-1-k)) u_step (
            .clock (clock), .reset (reset), .en (en),
            .v_i (s_v[k-1]), .r_i (s_r[k-1]), .q_i (s_q[k-1]), .ovf_i (s_ovf[k-1]),
            .d_i (s_d[k-1]), .side_i (s_side[k-1]),
            .v_o (s_v[k]), .r_o (s_r[k]), .q_o (s_q[k]), .ovf_o (s_ovf[k]),
            .d_o (s_d[k]), .side_o (s_side[k])
         );
      end
   end

   always_comb begin
      sing_in = s_side[QUOT_W-1].singular;
      ovf_in  = s_side[QUOT_W-1].det_ovf;
      det_in  = s_side[QUOT_W-1].det_q;
      for (int i = 0; i < N_ENTRY; i++) begin
         if (s_side[QUOT_W-1].sneg[i]) begin
            if (s_ovf[QUOT_W-1][i] || s_q[QUOT_W-1][i] > SAT_NEG) begin
               inv_in[i] = SAT_NEG;
               ovf_in    = 1'b1;
            end else begin
               inv_in[i] = ENTRY_W'(0) - s_q[QUOT_W-1][i];
            end
         end else begin
            if (s_ovf[QUOT_W-1][i] || s_q[QUOT_W-1][i][QUOT_W-1]) begin
               inv_in[i] = SAT_POS;
               ovf_in    = 1'b1;
            end else begin
               inv_in[i] = s_q[QUOT_W-1][i];
            end
         end
      end
      if (sing_in) begin
         for (int i = 0; i < N_ENTRY; i++) begin
            inv_in[i] = '0;
         end
         det_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= s_v[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff  <= inv_in;
         det_ff  <= det_in;
         sing_ff <= sing_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_inv00       = inv_ff[0];
   assign rsp_inv01       = inv_ff[1];
   assign rsp_inv02       = inv_ff[2];
   assign rsp_inv10       = inv_ff[3];
   assign rsp_inv11       = inv_ff[4];
   assign rsp_inv12       = inv_ff[5];
   assign rsp_inv20       = inv_ff[6];
   assign rsp_inv21       = inv_ff[7];
   assign rsp_inv22       = inv_ff[8];
   assign rsp_determinant = det_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_overflow    = ovf_ff;

   `MI_ASSERT_NOW(a_singular_zero, clock, reset, rsp_valid && rsp_singular, rsp_determinant == '0 && !rsp_overflow && rsp_inv00 == '0 && rsp_inv11 == '0 && rsp_inv22 == '0, "singular result not cleared")
   `MI_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_inv00) && $stable(rsp_determinant) && $stable(rsp_overflow), "stalled result changed")
   `MI_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "request taken while pipeline stalled")
endmodule
`default_nettype wire

@@ sim/tb_matrix3x3_inverse_top.sv @@
// Self-checking testbench for matrix3x3_inverse_top: a directed table, then random matrices,
// each result compared with a behavioral Q16.16 inverse predictor.
// Depends on mi_pkg and the matrix3x3_inverse_top RTL.
`default_nettype none
module tb_matrix3x3_inverse_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mi_pkg::*;

   localparam int FRAC = 16;
   localparam int N_RANDOM = 1430;
   localparam int LATENCY = 39;
   localparam longint LIMIT = 400000;

   typedef struct {
      entry_type inv[9];
      entry_type det;
      logic      sing;
      logic      ovf;
   } inverse_type;

   typedef struct {
      entry_type   m[9];
      logic        known;
      inverse_type res;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   entry_type req_m [9];
   logic req_ready, rsp_valid, rsp_singular, rsp_overflow;
   entry_type rsp_inv [9];
   entry_type rsp_determinant;

   inverse_type inverse_q[$];
   int n_err = 0, n_sing = 0, n_ovf = 0, n_rsp = 0;
   longint cyc = 0;
   bit hold_phase = 0, no_idle = 0, stim_done = 0;

   initial for (int i = 0; i < 9; i++) req_m[i] = '0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   matrix3x3_inverse_top i_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid, .rsp_ready,
      .rsp_inv00(rsp_inv[0]), .rsp_inv01(rsp_inv[1]), .rsp_inv02(rsp_inv[2]),
      .rsp_inv10(rsp_inv[3]), .rsp_inv11(rsp_inv[4]), .rsp_inv12(rsp_inv[5]),
      .rsp_inv20(rsp_inv[6]), .rsp_inv21(rsp_inv[7]), .rsp_inv22(rsp_inv[8]),
      .rsp_determinant, .rsp_singular, .rsp_overflow
   );

   function automatic entry_type sat_q(logic [199:0] mag, logic neg, ref logic ovf);
      if (neg) begin
         if (mag > 200'h8000_0000) begin
            ovf = 1;
            return SAT_NEG;
         end
         return entry_type'(-mag[31:0]);
      end
      if (mag > 200'h7FFF_FFFF) begin
         ovf = 1;
         return SAT_POS;
      end
      return entry_type'(mag[31:0]);
   endfunction

   function automatic inverse_type invert(entry_type m[9]);
      logic signed [199:0] w[9];
      logic signed [199:0] adj[9];
      logic signed [199:0] det;
      logic [199:0] dmag, amag;
      inverse_type r;
      logic ovf;
      ovf = 0;
      for (int i = 0; i < 9; i++) w[i] = 200'(m[i]);
      adj[0] = w[4]*w[8] - w[5]*w[7];
      adj[1] = w[2]*w[7] - w[1]*w[8];
      adj[2] = w[1]*w[5] - w[2]*w[4];
      adj[3] = w[5]*w[6] - w[3]*w[8];
      adj[4] = w[0]*w[8] - w[2]*w[6];
      adj[5] = w[2]*w[3] - w[0]*w[5];
      adj[6] = w[3]*w[7] - w[4]*w[6];
      adj[7] = w[1]*w[6] - w[0]*w[7];
      adj[8] = w[0]*w[4] - w[1]*w[3];
      det = w[0]*adj[0] + w[1]*adj[3] + w[2]*adj[6];
      r.sing = 0;
      if (det == 0) begin
         for (int i = 0; i < 9; i++) r.inv[i] = '0;
         r.det = '0;
         r.sing = 1;
         r.ovf = 0;
         return r;
      end
      dmag = det < 0 ? -det : det;
      for (int i = 0; i < 9; i++) begin
         amag = adj[i] < 0 ? -adj[i] : adj[i];
         r.inv[i] = sat_q((amag << (2*FRAC)) / dmag, (adj[i] < 0) != (det < 0), ovf);
      end
      r.det = sat_q(dmag >> (2*FRAC), det < 0, ovf);
      r.ovf = ovf;
      return r;
   endfunction

   task automatic send(row_type row);
      inverse_type e;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      e = invert(row.m);
      if (row.known && e != row.res) begin
         $error("directed row disagrees with predictor");
         n_err++;
      end
      req_valid <= 1;
      for (int i = 0; i < 9; i++) req_m[i] <= row.m[i];
      do @(posedge clock); while (!req_ready);
      inverse_q.push_back(row.known ? row.res : e);
   endtask

   function automatic row_type mk(entry_type a[9]);
      row_type r;
      r.m = a;
      r.known = 0;
      return r;
   endfunction

   function automatic row_type mk_known(entry_type a[9], inverse_type x);
      row_type r;
      r.m = a;
      r.known = 1;
      r.res = x;
      return r;
   endfunction

   function automatic entry_type rnd_entry();
      case ($urandom_range(0, 5))
         0: return entry_type'($urandom);
         1: return entry_type'($urandom_range(0, 4) << 16) * ($urandom_range(0, 1) ? 1 : -1);
         2: return entry_type'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
         3: return $urandom_range(0, 1) ? SAT_NEG : SAT_POS;
         4: return entry_type'($signed($urandom_range(0, 64)) - 32);
         default: return entry_type'($signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
      endcase
   endfunction

   initial begin
      row_type table_q[$];
      entry_type a[9];
      inverse_type x;
      localparam entry_type ONE = 32'sh1_0000;
      repeat (4) @(posedge clock);
      reset <= 0;

      // identity: inverse is identity, det one
      a = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      x.inv = a; x.det = ONE; x.sing = 0; x.ovf = 0;
      table_q.push_back(mk_known(a, x));
      // all zero: singular
      a = '{default: 0};
      x.inv = '{default: 0}; x.det = 0; x.sing = 1; x.ovf = 0;
      table_q.push_back(mk_known(a, x));
      // equal rows: singular
      a = '{SAT_POS, 3, 5, SAT_POS, 3, 5, 1, 2, 9};
      table_q.push_back(mk_known(a, x));
      // diag 2: inverse 0.5, det 8
      a = '{2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE};
      x.inv = '{32'sh8000, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000};
      x.det = 8*ONE; x.sing = 0; x.ovf = 0;
      table_q.push_back(mk_known(a, x));
      // tiny determinant: det truncates to 0, inverse saturates
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      x.inv = '{SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS};
      x.det = 0; x.sing = 0; x.ovf = 1;
      table_q.push_back(mk_known(a, x));
      // negative tiny
      a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
      table_q.push_back(mk(a));
      // extremes: det saturates
      a = '{SAT_NEG, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_NEG};
      table_q.push_back(mk(a));
      a = '{SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS};
      table_q.push_back(mk(a));
      a = '{SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_NEG, SAT_POS, SAT_POS, SAT_NEG};
      table_q.push_back(mk(a));
      a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      table_q.push_back(mk(a));
      a = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
      table_q.push_back(mk(a));
      a = '{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0};
      table_q.push_back(mk(a));
      a = '{-ONE, 0, 0, 0, 3*ONE, 0, 0, 0, -7*ONE};
      table_q.push_back(mk(a));
      foreach (table_q[i]) send(table_q[i]);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 300) hold_phase = 1;
         if (n == N_RANDOM - 150) no_idle = 1;
         for (int i = 0; i < 9; i++) a[i] = rnd_entry();
         if ($urandom_range(0, 9) == 0) begin
            // force linear dependence
            a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
         end
         send(mk(a));
      end
      req_valid <= 0;
      stim_done = 1;
   end

   // response side: random backpressure, plus one long hold-off
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         if (hold_phase) begin
            hold_phase = 0;
            rsp_ready <= 0;
            hold = 0;
            while (hold < 200) begin
               @(posedge clock);
               hold++;
            end
         end
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      inverse_type e;
      cyc <= cyc + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inverse_q.size() == 0) begin
            $error("result with nothing pending");
            n_err++;
         end else begin
            e = inverse_q.pop_front();
            n_rsp++;
            n_sing += rsp_singular;
            n_ovf += rsp_overflow;
            for (int i = 0; i < 9; i++)
               if (rsp_inv[i] !== e.inv[i]) begin
                  $error("inv%0d%0d: expected %h, got %h", i/3, i%3, e.inv[i], rsp_inv[i]);
                  n_err++;
               end
            if (rsp_determinant !== e.det) begin
               $error("determinant: expected %h, got %h", e.det, rsp_determinant);
               n_err++;
            end
            if (rsp_singular !== e.sing) begin
               $error("singular: expected %b, got %b", e.sing, rsp_singular);
               n_err++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow: expected %b, got %b", e.ovf, rsp_overflow);
               n_err++;
            end
         end
      end
   end

   initial begin
      while (!(stim_done && inverse_q.size() == 0)) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("checked %0d inverses: %0d singular, %0d saturated", n_rsp, n_sing, n_ovf);
      if (n_err == 0 && inverse_q.size() == 0)
         $display("tb_matrix3x3_inverse_top: done, clean");
      else
         $display("tb_matrix3x3_inverse_top: done, errors");
      $finish;
   end

   initial begin
      wait (cyc >= LIMIT);
      $display("timeout after %0d cycles", cyc);
      $display("tb_matrix3x3_inverse_top: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

@@ matrix3x3_inverse_top.f @@
+incdir+rtl
rtl/mi_pkg.sv
rtl/mi_adj.sv
rtl/mi_det.sv
rtl/mi_div_step.sv
rtl/matrix3x3_inverse_top.sv
sim/tb_matrix3x3_inverse_top.sv
